@@ rtl/core/mmpp_pkg.sv @@
// ----------------------------------------------------------------------------
// MMPP policer package
// Word types, register indexes and constants shared by the policer modules.
// ----------------------------------------------------------------------------
package mmpp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 3'd5;

    // Source states
    localparam logic [1:0] MODE_ONE = 2'd1;
    localparam logic [1:0] MODE_TWO = 2'd2;

    // Register reset values
    localparam logic [31:0] WINDOW_LEN_RESET  = 32'd1000000000;
    localparam logic [8:0]  QUEUE_LIMIT_RESET = 9'd300;

    // Mixed-radix split of 32-bit counts: high digit counts millions,
    // low digit holds the remainder below one million.
    localparam int unsigned   HI_W         = 13;
    localparam int unsigned   LO_W         = 20;
    localparam logic [LO_W-1:0] SMOOTH_SCALE = 20'd1000000;
    localparam logic [LO_W-1:0] SCALE_LO_TOP = 20'd999999;

    typedef struct packed {
        logic [63:0] arrival_time;
        logic [31:0] random_value;
        logic [15:0] packet_length;
    } in_word_t;

    typedef struct packed {
        logic        drop;
        logic [1:0]  source_state;
        logic [31:0] active_rate;
        logic [31:0] mean_count;
        logic [31:0] window_count;
        logic [8:0]  queue_fill;
        logic [47:0] record_rx_packets;
        logic [55:0] record_rx_bytes;
        logic [47:0] dropped_total;
        logic [47:0] passed_packets;
        logic [55:0] passed_bytes;
    } out_word_t;

    // Control from the policer core into the average tracker
    typedef struct packed {
        logic step;
        logic roll;
    } avg_ctl_t;

    // Status from the average tracker
    typedef struct packed {
        logic [31:0] smooth;
        logic [31:0] smooth_roll;
        logic [31:0] count_inc;
    } avg_view_t;

endpackage

@@ rtl/core/mmpp_avg_track.sv @@
// ----------------------------------------------------------------------------
// MMPP window average tracker
// Holds the per-window packet count and the smoothed count, each kept both
// in binary and split into millions and remainder, so the rollover update
// (smooth*999999 + count)/1000000 reduces to narrow digit arithmetic.
// ----------------------------------------------------------------------------
module mmpp_avg_track (
    input  logic                aclk,
    input  logic                aresetn,
    input  mmpp_pkg::avg_ctl_t  ctl,
    output mmpp_pkg::avg_view_t view
);
    import mmpp_pkg::*;

    logic [31:0]     cnt_reg, cnt_next;
    logic [HI_W-1:0] cnt_hi_reg, cnt_hi_next;
    logic [LO_W-1:0] cnt_lo_reg, cnt_lo_next;
    logic [31:0]     sm_reg, sm_next;
    logic [HI_W-1:0] sm_hi_reg, sm_hi_next;
    logic [LO_W-1:0] sm_lo_reg, sm_lo_next;

    logic            borrow;
    logic [HI_W:0]   quot;
    logic [LO_W+1:0] lo_sum;
    logic [31:0]     sm_roll;
    logic [HI_W-1:0] sm_hi_roll;
    logic [LO_W-1:0] sm_lo_roll;
    logic            cnt_full;
    logic            lo_wrap;
    logic [31:0]     cnt_inc;
    logic [HI_W-1:0] cnt_hi_inc;
    logic [LO_W-1:0] cnt_lo_inc;

    // Quotient of (count - smooth) / 1e6, floored, from the digits
    always_comb begin
        borrow = (cnt_lo_reg < sm_lo_reg);
        quot   = {1'b0, cnt_hi_reg} - {1'b0, sm_hi_reg} - {{HI_W{1'b0}}, borrow};
        sm_roll = sm_reg + {{(32-HI_W-1){quot[HI_W]}}, quot};
        lo_sum  = {2'b00, sm_lo_reg} + {{(LO_W+1-HI_W){quot[HI_W]}}, quot};
        // Renormalize the remainder digit after adding the quotient
        if (lo_sum[LO_W+1]) begin
            sm_lo_roll = LO_W'(lo_sum + {2'b00, SMOOTH_SCALE});
            sm_hi_roll = sm_hi_reg - {{(HI_W-1){1'b0}}, 1'b1};
        end else if (lo_sum[LO_W:0] >= {1'b0, SMOOTH_SCALE}) begin
            sm_lo_roll = LO_W'(lo_sum - {2'b00, SMOOTH_SCALE});
            sm_hi_roll = sm_hi_reg + {{(HI_W-1){1'b0}}, 1'b1};
        end else begin
            sm_lo_roll = lo_sum[LO_W-1:0];
            sm_hi_roll = sm_hi_reg;
        end
    end

    // Saturating increment of the window count, in both forms
    always_comb begin
        cnt_full = (cnt_reg == '1);
        lo_wrap  = (cnt_lo_reg == SCALE_LO_TOP);
        if (cnt_full) begin
            cnt_inc    = cnt_reg;
            cnt_hi_inc = cnt_hi_reg;
            cnt_lo_inc = cnt_lo_reg;
        end else begin
            cnt_inc    = cnt_reg + 32'd1;
            cnt_hi_inc = lo_wrap ? cnt_hi_reg + {{(HI_W-1){1'b0}}, 1'b1} : cnt_hi_reg;
            cnt_lo_inc = lo_wrap ? '0 : cnt_lo_reg + {{(LO_W-1){1'b0}}, 1'b1};
        end
    end

    // Next state: restart the window on rollover, else count the packet
    always_comb begin
        cnt_next    = cnt_reg;
        cnt_hi_next = cnt_hi_reg;
        cnt_lo_next = cnt_lo_reg;
        sm_next     = sm_reg;
        sm_hi_next  = sm_hi_reg;
        sm_lo_next  = sm_lo_reg;
        if (ctl.step) begin
            if (ctl.roll) begin
                cnt_next    = 32'd1;
                cnt_hi_next = '0;
                cnt_lo_next = {{(LO_W-1){1'b0}}, 1'b1};
                sm_next     = sm_roll;
                sm_hi_next  = sm_hi_roll;
                sm_lo_next  = sm_lo_roll;
            end else begin
                cnt_next    = cnt_inc;
                cnt_hi_next = cnt_hi_inc;
                cnt_lo_next = cnt_lo_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cnt_hi_reg <= '0;
            cnt_lo_reg <= '0;
            sm_reg     <= '0;
            sm_hi_reg  <= '0;
            sm_lo_reg  <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            cnt_hi_reg <= cnt_hi_next;
            cnt_lo_reg <= cnt_lo_next;
            sm_reg     <= sm_next;
            sm_hi_reg  <= sm_hi_next;
            sm_lo_reg  <= sm_lo_next;
        end
    end

    assign view.smooth      = sm_reg;
    assign view.smooth_roll = sm_roll;
    assign view.count_inc   = cnt_inc;

endmodule

@@ rtl/core/mmpp_packet_policer.sv @@
// ----------------------------------------------------------------------------
// MMPP packet policer
// Per packet: window rollover with smoothed-count update, two-state source
// transition, pass/drop verdict against queue fill and rate, statistics.
// ----------------------------------------------------------------------------
// A word accepted on s_ passes the input register and then the result register
// before it appears on m_.
// Throughput: one word per cycle while m_ready is high; the verdict path is a
// single pass: window compare, digit-based average update, rate compare.
// Reset: statistics, window state and fill clear, source returns to state
// one, registers take their defaults; no clearing pass.
module mmpp_packet_policer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mmpp_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mmpp_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import mmpp_pkg::*;

    // Configuration registers
    logic [31:0] rate_one_reg, rate_two_reg, leave_two_reg, leave_one_reg;
    logic [31:0] window_len_reg;
    logic [8:0]  queue_limit_reg;

    // Pipeline registers
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    // Policer state
    logic [63:0] win_begin_reg, win_begin_next;
    logic [1:0]  mode_reg, mode_next;
    logic [8:0]  fill_reg, fill_next;
    logic [47:0] pass_pkts_reg, pass_pkts_next;
    logic [55:0] pass_bytes_reg, pass_bytes_next;
    logic [47:0] drop_pkts_reg, drop_pkts_next;
    logic [55:0] drop_bytes_reg, drop_bytes_next;

    logic        out_free;
    logic        step;
    logic [63:0] elapsed;
    logic        roll;
    logic [31:0] rate;
    logic [31:0] smooth_eff;
    logic        drop;
    logic [47:0] pass_pkts_inc, drop_pkts_inc;
    logic [56:0] pass_bytes_sum, drop_bytes_sum;
    logic [55:0] pass_bytes_inc, drop_bytes_inc;
    logic [8:0]  fill_inc;

    avg_ctl_t    avg_ctl;
    avg_view_t   avg_view;

    // Handshake: input register advances whenever the result slot frees
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (step) begin
            out_word_reg <= out_word_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_one_reg    <= '0;
            rate_two_reg    <= '0;
            leave_two_reg   <= '0;
            leave_one_reg   <= '0;
            window_len_reg  <= WINDOW_LEN_RESET;
            queue_limit_reg <= QUEUE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RATE_ONE:    rate_one_reg    <= cfg_data;
                REG_RATE_TWO:    rate_two_reg    <= cfg_data;
                REG_LEAVE_TWO:   leave_two_reg   <= cfg_data;
                REG_LEAVE_ONE:   leave_one_reg   <= cfg_data;
                REG_WINDOW_LEN:  window_len_reg  <= cfg_data;
                REG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Window and average tracking
    assign avg_ctl.step = step;
    assign avg_ctl.roll = roll;

    mmpp_avg_track u_avg_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (avg_ctl),
        .view    (avg_view)
    );

    // Window rollover, source transition and pass/drop verdict
    always_comb begin
        elapsed = in_word_reg.arrival_time - win_begin_reg;
        roll    = (elapsed >= {32'd0, window_len_reg});
        win_begin_next = roll ? in_word_reg.arrival_time : win_begin_reg;
        smooth_eff     = roll ? avg_view.smooth_roll : avg_view.smooth;

        mode_next = mode_reg;
        if (mode_reg == MODE_ONE && in_word_reg.random_value < leave_one_reg) begin
            mode_next = MODE_TWO;
        end else if (mode_reg == MODE_TWO && in_word_reg.random_value < leave_two_reg) begin
            mode_next = MODE_ONE;
        end
        rate = (mode_next == MODE_ONE) ? rate_one_reg : rate_two_reg;
        drop = (fill_reg > queue_limit_reg) || (rate < smooth_eff);
    end

    // Saturating counter increments
    always_comb begin
        pass_pkts_inc  = (pass_pkts_reg == '1) ? pass_pkts_reg : pass_pkts_reg + 48'd1;
        drop_pkts_inc  = (drop_pkts_reg == '1) ? drop_pkts_reg : drop_pkts_reg + 48'd1;
        pass_bytes_sum = {1'b0, pass_bytes_reg} + {41'd0, in_word_reg.packet_length};
        drop_bytes_sum = {1'b0, drop_bytes_reg} + {41'd0, in_word_reg.packet_length};
        pass_bytes_inc = pass_bytes_sum[56] ? '1 : pass_bytes_sum[55:0];
        drop_bytes_inc = drop_bytes_sum[56] ? '1 : drop_bytes_sum[55:0];
        fill_inc       = (fill_reg == '1) ? fill_reg : fill_reg + 9'd1;
    end

    // Apply the verdict to the statistics
    always_comb begin
        fill_next       = fill_reg;
        pass_pkts_next  = pass_pkts_reg;
        pass_bytes_next = pass_bytes_reg;
        drop_pkts_next  = drop_pkts_reg;
        drop_bytes_next = drop_bytes_reg;
        if (drop) begin
            drop_pkts_next  = drop_pkts_inc;
            drop_bytes_next = drop_bytes_inc;
        end else begin
            fill_next       = fill_inc;
            pass_pkts_next  = pass_pkts_inc;
            pass_bytes_next = pass_bytes_inc;
        end
    end

    // Build the result word
    always_comb begin
        out_word_next.drop              = drop;
        out_word_next.source_state      = mode_next;
        out_word_next.active_rate       = rate;
        out_word_next.mean_count        = smooth_eff;
        out_word_next.window_count      = roll ? 32'd1 : avg_view.count_inc;
        out_word_next.queue_fill        = fill_next;
        out_word_next.record_rx_packets = drop ? drop_pkts_next : pass_pkts_next;
        out_word_next.record_rx_bytes   = drop ? drop_bytes_next : pass_bytes_next;
        out_word_next.dropped_total     = drop_pkts_next;
        out_word_next.passed_packets    = pass_pkts_next;
        out_word_next.passed_bytes      = pass_bytes_next;
    end

    // Commit state when the word moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_begin_reg  <= '0;
            mode_reg       <= MODE_ONE;
            fill_reg       <= '0;
            pass_pkts_reg  <= '0;
            pass_bytes_reg <= '0;
            drop_pkts_reg  <= '0;
            drop_bytes_reg <= '0;
        end else if (step) begin
            win_begin_reg  <= win_begin_next;
            mode_reg       <= mode_next;
            fill_reg       <= fill_next;
            pass_pkts_reg  <= pass_pkts_next;
            pass_bytes_reg <= pass_bytes_next;
            drop_pkts_reg  <= drop_pkts_next;
            drop_bytes_reg <= drop_bytes_next;
        end
    end

endmodule
